### rtl/rc5cd_pkg.sv
// Shared types, constants and helpers for the RC5 infrared command decoder.
// No dependencies; every other file of the block imports this package.
package rc5cd_pkg;

    localparam int TIME_W  = 16;
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 5;
    localparam int CMD_W   = 7;
    localparam int WORD_W  = 14;
    localparam int CNT_W   = 4;
    localparam int INDEX_W = 2;

    localparam logic [CFG_W-1:0] HALF_MIN_RST = 16'd640;
    localparam logic [CFG_W-1:0] HALF_MAX_RST = 16'd1140;
    localparam logic [CFG_W-1:0] FULL_MIN_RST = 16'd1400;
    localparam logic [CFG_W-1:0] FULL_MAX_RST = 16'd2100;

    // Bits still to gather after the start bit, and the count once all are in
    localparam logic [CNT_W-1:0] FRAME_BITS = 4'd13;
    localparam logic [CNT_W-1:0] BITS_DONE  = 4'd15;
    localparam logic [CNT_W-1:0] WORD_LEN   = CNT_W'(WORD_W);

    // Frame word layout below the start bit
    localparam int FIELD_POS  = 12;
    localparam int TOGGLE_POS = 11;
    localparam int ADDR_LSB   = 6;
    localparam int CMD_LOW_W  = 6;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [WORD_W-2:0] frame_word_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_HALF_MIN = 2'd0,
        REG_HALF_MAX = 2'd1,
        REG_FULL_MIN = 2'd2,
        REG_FULL_MAX = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        WIDTH_HALF = 2'd0,
        WIDTH_FULL = 2'd1,
        WIDTH_BAD  = 2'd2
    } width_class_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    function automatic logic in_window(logic [TIME_W-1:0] w, logic [CFG_W-1:0] lo,
                                       logic [CFG_W-1:0] hi);
        return (w >= lo) && (w <= hi);
    endfunction

endpackage

### rtl/rc5cd_if.sv
// Handshake channels of the RC5 decoder: capture words in, decoded results out.
// Depends on rc5cd_pkg for field widths.
interface rc5cd_capture_if import rc5cd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [TIME_W-1:0] edge_time;
    logic              edge_falling;

    modport source (output valid, output mode, output edge_time, output edge_falling,
                    input ready);
    modport sink (input valid, input mode, input edge_time, input edge_falling,
                  output ready);
endinterface

interface rc5cd_result_if import rc5cd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] device_address;
    logic [CMD_W-1:0]  command_code;

    modport source (output valid, output device_address, output command_code,
                    input ready);
    modport sink (input valid, input device_address, input command_code,
                  output ready);
endinterface

### rtl/rc5cd_front.sv
// Front end: polarity filter, pulse width windows, frame sequencer and repeat filter.
// Pushes each reported frame word into the queue. Depends on rc5cd_pkg, rc5cd_if.
module rc5cd_front import rc5cd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    rc5cd_capture_if.sink        capture,
    input  logic                 cfg_wr_en,
    input  logic [INDEX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  queue_status_t        qstat,
    output logic                 push,
    output frame_word_t          push_word
);

    logic [CFG_W-1:0]  half_min_reg, half_max_reg, full_min_reg, full_max_reg;
    logic [TIME_W-1:0] prev_time_reg, prev_time_next;
    logic              expect_rising_reg, expect_rising_next;
    logic              frame_active_reg, frame_active_next;
    logic [CNT_W-1:0]  bits_left_reg, bits_left_next;
    logic [WORD_W-1:0] shift_word_reg, shift_word_next;
    logic              at_boundary_reg, at_boundary_next;
    logic              last_toggle_reg, last_toggle_next;
    logic              first_frame_reg, first_frame_next;
    logic              pending_reg, pending_next;

    logic              accept;
    logic [TIME_W-1:0] width;
    width_class_t      width_class;
    logic              store;
    logic [CNT_W-1:0]  bits_base;
    logic [WORD_W-1:0] shift_base;

    assign capture.ready = ~qstat.full;
    assign accept        = capture.valid & capture.ready;
    assign width         = capture.edge_time - prev_time_reg;

    // Half window wins where the two overlap
    always_comb
    begin
        if (in_window(width, half_min_reg, half_max_reg))
            width_class = WIDTH_HALF;
        else if (in_window(width, full_min_reg, full_max_reg))
            width_class = WIDTH_FULL;
        else
            width_class = WIDTH_BAD;
    end

    always_comb
    begin
        prev_time_next     = prev_time_reg;
        expect_rising_next = expect_rising_reg;
        frame_active_next  = frame_active_reg;
        bits_left_next     = bits_left_reg;
        shift_word_next    = shift_word_reg;
        at_boundary_next   = at_boundary_reg;
        last_toggle_next   = last_toggle_reg;
        first_frame_next   = first_frame_reg;
        pending_next       = pending_reg;
        store              = 1'b0;
        bits_base          = bits_left_reg;
        shift_base         = shift_word_reg;
        push               = 1'b0;

        if (accept)
        begin
            if (capture.mode)
            begin
                pending_next = 1'b0;
            end
            else if (capture.edge_falling != expect_rising_reg)
            begin
                prev_time_next = capture.edge_time;
                if (!pending_reg)
                begin
                    if (!frame_active_reg)
                    begin
                        // start bit opens a new frame
                        bits_base         = FRAME_BITS;
                        shift_base        = '0;
                        store             = 1'b1;
                        frame_active_next = 1'b1;
                    end
                    else if (at_boundary_reg)
                    begin
                        case (width_class)
                            WIDTH_HALF: at_boundary_next  = 1'b0;
                            WIDTH_FULL: store             = 1'b1;
                            default:    frame_active_next = 1'b0;
                        endcase
                    end
                    else if (width_class == WIDTH_HALF)
                    begin
                        store = 1'b1;
                    end
                    else
                    begin
                        frame_active_next = 1'b0;
                    end

                    bits_left_next  = bits_base;
                    shift_word_next = shift_base;
                    if (store)
                    begin
                        if (bits_base < WORD_LEN)
                            shift_word_next = shift_base
                                | (WORD_W'(capture.edge_falling) << bits_base);
                        bits_left_next   = bits_base - 1'b1;
                        at_boundary_next = 1'b1;
                    end

                    if (bits_left_next == BITS_DONE)
                    begin
                        // drop a repeat of the last reported frame
                        if (frame_active_next &&
                            (shift_word_next[TOGGLE_POS] != last_toggle_reg ||
                             first_frame_reg))
                        begin
                            push             = 1'b1;
                            pending_next     = 1'b1;
                            last_toggle_next = shift_word_next[TOGGLE_POS];
                            first_frame_next = 1'b0;
                        end
                        frame_active_next = 1'b0;
                    end
                end
                expect_rising_next = frame_active_next ? ~expect_rising_reg : 1'b0;
            end
        end
    end

    assign push_word = shift_word_next[WORD_W-2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_min_reg <= HALF_MIN_RST;
            half_max_reg <= HALF_MAX_RST;
            full_min_reg <= FULL_MIN_RST;
            full_max_reg <= FULL_MAX_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                REG_HALF_MIN: half_min_reg <= cfg_wdata;
                REG_HALF_MAX: half_max_reg <= cfg_wdata;
                REG_FULL_MIN: full_min_reg <= cfg_wdata;
                REG_FULL_MAX: full_max_reg <= cfg_wdata;
                default:      half_min_reg <= half_min_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg     <= '0;
            expect_rising_reg <= 1'b0;
            frame_active_reg  <= 1'b0;
            bits_left_reg     <= FRAME_BITS;
            shift_word_reg    <= '0;
            at_boundary_reg   <= 1'b1;
            last_toggle_reg   <= 1'b0;
            first_frame_reg   <= 1'b1;
            pending_reg       <= 1'b0;
        end
        else
        begin
            prev_time_reg     <= prev_time_next;
            expect_rising_reg <= expect_rising_next;
            frame_active_reg  <= frame_active_next;
            bits_left_reg     <= bits_left_next;
            shift_word_reg    <= shift_word_next;
            at_boundary_reg   <= at_boundary_next;
            last_toggle_reg   <= last_toggle_next;
            first_frame_reg   <= first_frame_next;
            pending_reg       <= pending_next;
        end
    end

endmodule

### rtl/rc5cd_queue.sv
// Short word queue between front end and result stage.
// Depends on rc5cd_pkg.
module rc5cd_queue import rc5cd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  frame_word_t   push_word,
    input  logic          pop,
    output frame_word_t   pop_word,
    output queue_status_t qstat
);

    frame_word_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_word    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/rc5cd_back.sv
// Result stage: splits a frame word into address and command and holds it
// in the output register. Depends on rc5cd_pkg, rc5cd_if.
module rc5cd_back import rc5cd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  queue_status_t  qstat,
    input  frame_word_t    pop_word,
    output logic           pop,
    rc5cd_result_if.source result
);

    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [CMD_W-1:0]  cmd_reg;

    // load whenever the register is free or its word leaves this cycle
    assign pop = ~qstat.empty & (~valid_reg | result.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // field bit is sent inverted as command bit 6
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            addr_reg <= pop_word[ADDR_LSB +: ADDR_W];
            cmd_reg  <= {~pop_word[FIELD_POS], pop_word[CMD_LOW_W-1:0]};
        end
    end

    assign result.valid          = valid_reg;
    assign result.device_address = addr_reg;
    assign result.command_code   = cmd_reg;

endmodule

### rtl/rc5_infrared_command_decoder_unit.sv
// Top level of the RC5 infrared command decoder: front end, queue, result stage.
// Depends on rc5cd_pkg, rc5cd_if, rc5cd_front, rc5cd_queue, rc5cd_back.
//
//  channel   dir  handshake     payload
//  capture   in   valid/ready   mode, edge_time[15:0], edge_falling
//  result    out  valid/ready   device_address[4:0], command_code[6:0]
//  cfg       in   cfg_wr_en     cfg_index[1:0], cfg_wdata[15:0]
//
// One capture word per cycle while capture ready is high; each word is decoded in the cycle it is taken.
// A reported frame is registered in the queue and then in the result register before it shows on result.
// Capture ready drops only while the two-word queue is full, which happens
// only while result is stalled. Reset clears all control state at once.
module rc5_infrared_command_decoder_unit import rc5cd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    rc5cd_capture_if.sink      capture,
    rc5cd_result_if.source     result,
    input  logic               cfg_wr_en,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata
);

    logic          push;
    logic          pop;
    frame_word_t   push_word;
    frame_word_t   pop_word;
    queue_status_t qstat;

    rc5cd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .capture   (capture),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .qstat     (qstat),
        .push      (push),
        .push_word (push_word)
    );

    rc5cd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .qstat     (qstat)
    );

    rc5cd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .pop_word (pop_word),
        .pop      (pop),
        .result   (result)
    );

endmodule

### rtl/rc5cd_checker.sv
// Port-level checks for the RC5 decoder top level, attached by bind.
// Depends on rc5cd_pkg and rc5_infrared_command_decoder_unit.
module rc5cd_checker import rc5cd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cap_valid,
    input logic              cap_ready,
    input logic              cap_mode,
    input logic              res_valid,
    input logic              res_ready,
    input logic [ADDR_W-1:0] res_address,
    input logic [CMD_W-1:0]  res_command
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_address) && $stable(res_command))
        else $error("result word changed while stalled");

    // a fresh result follows an edge word registered in the queue and then in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cap_valid && cap_ready && !cap_mode, 2))
        else $error("result without a preceding edge word");

    // the queue fills only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !cap_ready |-> res_valid)
        else $error("capture stalled with no result waiting");

endmodule

bind rc5_infrared_command_decoder_unit rc5cd_checker u_rc5cd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cap_valid   (capture.valid),
    .cap_ready   (capture.ready),
    .cap_mode    (capture.mode),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_address (result.device_address),
    .res_command (result.command_code)
);

### test/tb_rc5_infrared_command_decoder_unit.sv
// Self-checking bench for the RC5 infrared command decoder: edge words are
// decoded by a local model and every result word is compared against it.
// Depends on rc5cd_pkg, the rc5cd channel interfaces and the decoder RTL.
`timescale 1ns / 100ps

module tb_rc5_infrared_command_decoder_unit;
    import rc5cd_pkg::*;

    localparam logic MODE_EDGE  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;
    localparam int   SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CMD_W-1:0]  cmd;
    } rc5_command_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    cfg_index_t         cfg_index;
    logic [CFG_W-1:0]   cfg_wdata;

    rc5cd_capture_if capture_ch ();
    rc5cd_result_if  result_ch ();

    rc5_infrared_command_decoder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .capture   (capture_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Decoder model state
    logic [CFG_W-1:0]  win_limit [4];
    logic [TIME_W-1:0] m_prev_stamp;
    logic              m_want_rise;
    logic              m_in_frame;
    logic [CNT_W-1:0]  m_bits_left;
    logic [WORD_W-1:0] m_frame;
    logic              m_on_boundary;
    logic              m_last_toggle;
    logic              m_first;
    logic              m_pending;

    rc5_command_t      expected_cmds [$];

    int                errors;
    int                words_sent;
    int                frames_checked;
    int                settings_used;
    int                burst_left;
    logic [TIME_W-1:0] now_ticks;
    logic              tx_toggle;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR @%0t: %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    function automatic logic fits(logic [TIME_W-1:0] w, logic [CFG_W-1:0] lo,
                                  logic [CFG_W-1:0] hi);
        return (lo <= w) && (w <= hi);
    endfunction

    function automatic void reset_decoder_model();
        win_limit[REG_HALF_MIN] = HALF_MIN_RST;
        win_limit[REG_HALF_MAX] = HALF_MAX_RST;
        win_limit[REG_FULL_MIN] = FULL_MIN_RST;
        win_limit[REG_FULL_MAX] = FULL_MAX_RST;
        m_prev_stamp  = '0;
        m_want_rise   = 1'b0;
        m_in_frame    = 1'b0;
        m_bits_left   = FRAME_BITS;
        m_frame       = '0;
        m_on_boundary = 1'b1;
        m_last_toggle = 1'b0;
        m_first       = 1'b1;
        m_pending     = 1'b0;
    endfunction

    function automatic void latch_bit(logic b);
        if (m_bits_left < CNT_W'(WORD_W))
            m_frame[m_bits_left] = m_frame[m_bits_left] | b;
        m_bits_left   = m_bits_left - 1'b1;
        m_on_boundary = 1'b1;
    endfunction

    // Advance the model by one capture word; queue a command if a frame completes that is not a repeat
    function automatic void decode_capture(logic mode, logic [TIME_W-1:0] stamp,
                                           logic falling);
        logic [TIME_W-1:0] width;
        logic              half_ok;
        logic              full_ok;
        rc5_command_t      cmd_out;

        if (mode == MODE_CLEAR) begin
            m_pending = 1'b0;
            return;
        end
        if (falling == m_want_rise)
            return;

        width        = stamp - m_prev_stamp;
        m_prev_stamp = stamp;
        half_ok = fits(width, win_limit[REG_HALF_MIN], win_limit[REG_HALF_MAX]);
        full_ok = fits(width, win_limit[REG_FULL_MIN], win_limit[REG_FULL_MAX]);

        if (!m_pending) begin
            if (!m_in_frame) begin
                m_bits_left = FRAME_BITS;
                m_frame     = '0;
                latch_bit(falling);
                m_in_frame  = 1'b1;
            end
            else if (m_on_boundary) begin
                if (half_ok)
                    m_on_boundary = 1'b0;
                else if (full_ok)
                    latch_bit(falling);
                else
                    m_in_frame = 1'b0;
            end
            else begin
                if (half_ok)
                    latch_bit(falling);
                else
                    m_in_frame = 1'b0;
            end

            if (m_bits_left == BITS_DONE) begin
                if (m_in_frame && (m_frame[TOGGLE_POS] != m_last_toggle || m_first)) begin
                    cmd_out.addr = m_frame[ADDR_LSB +: ADDR_W];
                    cmd_out.cmd  = {~m_frame[FIELD_POS], m_frame[CMD_LOW_W-1:0]};
                    expected_cmds.push_back(cmd_out);
                    m_pending     = 1'b1;
                    m_last_toggle = m_frame[TOGGLE_POS];
                    m_first       = 1'b0;
                end
                m_in_frame = 1'b0;
            end
        end

        m_want_rise = m_in_frame ? ~m_want_rise : 1'b0;
    endfunction

    // Result side: check accepted words, stall on a changing pattern
    initial begin
        int           cyc;
        int           style;
        rc5_command_t want;

        cyc   = 0;
        style = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch("unexpected result word, address", result_ch.device_address,
                                    -1);
                end
                else begin
                    want = expected_cmds.pop_front();
                    frames_checked++;
                    if (result_ch.device_address !== want.addr)
                        report_mismatch("device_address", result_ch.device_address, want.addr);
                    if (result_ch.command_code !== want.cmd)
                        report_mismatch("command_code", result_ch.command_code, want.cmd);
                end
            end
            cyc++;
            if (cyc % 150 == 0)
                style = $urandom_range(0, 3);
            case (style)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= 1'($urandom_range(0, 1));
                2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= ((cyc % 16) < 8);
            endcase
        end
    end

    // Send one word; the burst keeps valid high, a burst end drops it for a gap
    task automatic send_word(input logic mode, input logic [TIME_W-1:0] stamp,
                             input logic falling);
        capture_ch.valid        <= 1'b1;
        capture_ch.mode         <= mode;
        capture_ch.edge_time    <= stamp;
        capture_ch.edge_falling <= falling;
        @(posedge clk);
        while (!capture_ch.ready)
            @(posedge clk);
        decode_capture(mode, stamp, falling);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            capture_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 7);
        end
    endtask

    task automatic send_edge(input logic [TIME_W-1:0] width, input logic falling);
        now_ticks = now_ticks + width;
        send_word(MODE_EDGE, now_ticks, falling);
    endtask

    // Hold the sender until every expected word is out, then let the block settle
    task automatic wait_idle();
        capture_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_windows(input logic [CFG_W-1:0] half_lo, input logic [CFG_W-1:0] half_hi,
                               input logic [CFG_W-1:0] full_lo, input logic [CFG_W-1:0] full_hi);
        logic [CFG_W-1:0] vals [4];

        vals = '{half_lo, half_hi, full_lo, full_hi};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
            win_limit[i] = vals[i];
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [TIME_W-1:0] pick_in(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
        return (lo <= hi) ? TIME_W'($urandom_range(hi, lo)) : TIME_W'($urandom);
    endfunction

    function automatic logic [TIME_W-1:0] pick_bad_width();
        logic [TIME_W-1:0] w;

        w = TIME_W'($urandom);
        for (int k = 0; k < 8 && (fits(w, win_limit[REG_HALF_MIN], win_limit[REG_HALF_MAX]) ||
                                  fits(w, win_limit[REG_FULL_MIN], win_limit[REG_FULL_MAX])); k++)
            w = TIME_W'($urandom);
        return w;
    endfunction

    // Manchester-encode one frame; break_at >= 0 spoils that bit with a bad width
    task automatic send_frame(input frame_word_t payload, input int break_at, input int noise_pct);
        logic p;
        logic b;
        logic half_open;
        logic full_open;

        half_open = win_limit[REG_HALF_MIN] <= win_limit[REG_HALF_MAX];
        full_open = win_limit[REG_FULL_MIN] <= win_limit[REG_FULL_MAX];
        send_edge(TIME_W'($urandom_range(6000, 1)), 1'b1);
        p = 1'b0;
        for (int i = WORD_W - 2; i >= 0; i--) begin
            b = payload[i];
            if ($urandom_range(0, 99) < noise_pct) begin
                if ($urandom_range(0, 3) == 0)
                    send_word(MODE_CLEAR, TIME_W'($urandom), 1'($urandom));
                else
                    send_word(MODE_EDGE, TIME_W'($urandom), ~p);
            end
            if (i == break_at) begin
                send_edge(pick_bad_width(), p);
                return;
            end
            // A bit equal to the next edge polarity needs a full width, else two halves
            if (b == p && !full_open)
                b = ~p;
            if (b != p && !half_open)
                b = p;
            if (b == p) begin
                send_edge(pick_in(win_limit[REG_FULL_MIN], win_limit[REG_FULL_MAX]), p);
                p = ~p;
            end
            else begin
                send_edge(pick_in(win_limit[REG_HALF_MIN], win_limit[REG_HALF_MAX]), p);
                send_edge(pick_in(win_limit[REG_HALF_MIN], win_limit[REG_HALF_MAX]), ~p);
            end
        end
    endtask

    task automatic run_frames(input int count, input int noise_pct, input int break_pct);
        frame_word_t payload;
        int          break_at;

        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) != 0)
                tx_toggle = ~tx_toggle;
            payload  = {1'($urandom), tx_toggle, 5'($urandom), 6'($urandom)};
            break_at = ($urandom_range(0, 99) < break_pct) ? $urandom_range(0, WORD_W - 2) : -1;
            send_frame(payload, break_at, noise_pct);
            if (m_pending) begin
                if ($urandom_range(0, 3) == 0)
                    send_edge(TIME_W'($urandom), 1'b1);
                if ($urandom_range(0, 9) != 0)
                    send_word(MODE_CLEAR, TIME_W'($urandom), 1'($urandom));
            end
        end
    endtask

    // Field extremes, timer wrap, ignored polarity, pending edges, clear, width error
    task automatic test_directed();
        logic p;

        send_word(MODE_EDGE, 16'h0000, 1'b0);
        now_ticks = 16'hF000;
        send_edge(16'd0, 1'b1);
        send_edge(HALF_MIN_RST, 1'b0);
        send_edge(HALF_MAX_RST, 1'b1);
        p = 1'b0;
        for (int i = 0; i < WORD_W - 2; i++) begin
            send_edge((i % 2 == 0) ? FULL_MIN_RST : FULL_MAX_RST, p);
            p = ~p;
        end
        send_word(MODE_EDGE, 16'hFFFF, 1'b1);
        send_word(MODE_CLEAR, 16'hFFFF, 1'b1);
        send_word(MODE_CLEAR, 16'h0000, 1'b0);
        now_ticks = 16'hFFFF;
        send_edge(16'd1, 1'b1);
        send_edge(FULL_MAX_RST + 16'd1, 1'b0);
        send_edge(16'd700, 1'b0);
        wait_idle();
    endtask

    task automatic test_clean_frames();
        run_frames(15, 0, 0);
        wait_idle();
    endtask

    task automatic test_noisy_frames();
        run_frames(12, 15, 0);
        wait_idle();
    endtask

    task automatic test_broken_frames();
        run_frames(10, 5, 70);
        wait_idle();
    endtask

    task automatic test_random_words();
        for (int n = 0; n < 200; n++)
            send_word(($urandom_range(0, 9) == 0) ? MODE_CLEAR : MODE_EDGE,
                      TIME_W'($urandom), 1'($urandom));
        send_word(MODE_CLEAR, TIME_W'($urandom), 1'($urandom));
        wait_idle();
    endtask

    // Window extremes, empty windows and overlap, ending back on the reset timing
    task automatic test_window_settings();
        set_windows(16'd0, 16'd0, 16'd1, 16'd1);
        run_frames(4, 5, 10);
        wait_idle();
        set_windows(16'd1, 16'd32767, 16'd32768, 16'd65535);
        run_frames(4, 5, 10);
        wait_idle();
        set_windows(16'd0, 16'd65535, 16'd65535, 16'd0);
        run_frames(4, 5, 10);
        wait_idle();
        set_windows(16'd65535, 16'd0, 16'd100, 16'd200);
        run_frames(4, 5, 10);
        wait_idle();
        set_windows(16'd300, 16'd900, 16'd800, 16'd1600);
        run_frames(4, 5, 10);
        wait_idle();
        set_windows(HALF_MIN_RST, HALF_MAX_RST, FULL_MIN_RST, FULL_MAX_RST);
        run_frames(4, 5, 10);
        wait_idle();
    endtask

    initial begin
        errors         = 0;
        words_sent     = 0;
        frames_checked = 0;
        settings_used  = 0;
        burst_left     = 0;
        now_ticks      = '0;
        tx_toggle      = 1'b0;
        reset_decoder_model();

        rst_n                   <= 1'b0;
        cfg_wr_en               <= 1'b0;
        cfg_index               <= REG_HALF_MIN;
        cfg_wdata               <= '0;
        capture_ch.valid        <= 1'b0;
        capture_ch.mode         <= MODE_EDGE;
        capture_ch.edge_time    <= '0;
        capture_ch.edge_falling <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_windows(HALF_MIN_RST, HALF_MAX_RST, FULL_MIN_RST, FULL_MAX_RST);
        test_directed();
        test_clean_frames();
        test_noisy_frames();
        test_broken_frames();
        test_random_words();
        test_window_settings();
        wait_idle();

        if (expected_cmds.size() != 0)
            report_mismatch("frames never reported", expected_cmds.size(), 0);
        $display("Sent %0d capture words over %0d window settings; %0d decoded frames checked",
                 words_sent, settings_used, frames_checked);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
